// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the stepper RTL; empty when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a condition on the next edge
`define ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_NEXT(label, clk, rst, trig, cond, msg)

`endif

`endif

// ===== hw/rtl/lps_pkg.sv =====
// Types, constants and helper functions of the line pixel stepper.
package lps_pkg;

   localparam int COORD_BITS     = 12;
   localparam int ERR_BITS       = COORD_BITS + 4;
   localparam int DASH_ON        = 5;
   localparam int DASH_BITS      = 3;
   localparam int GAP_BITS       = 8;
   localparam int CSR_INDEX_BITS = 2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_STYLE = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAP_LENGTH = CSR_INDEX_BITS'(1);

   // Transaction modes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   // Line styles
   localparam logic STYLE_SOLID  = 1'b0;
   localparam logic STYLE_DASHED = 1'b1;

   // Step direction codes
   localparam logic [1:0] DIR_NONE = 2'b00;
   localparam logic [1:0] DIR_POS  = 2'b01;
   localparam logic [1:0] DIR_NEG  = 2'b11;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic                  draw_pixel;
      logic                  last_pixel;
   } pixel_type;

   typedef struct packed {
      logic [DASH_BITS-1:0] on_cnt;
      logic [GAP_BITS-1:0]  gap_cnt;
      logic                 in_dash;
   } dash_type;

   // Advance the dash pattern by one pixel
   function automatic dash_type dash_step(input logic [DASH_BITS-1:0] on_cnt,
                                          input logic [GAP_BITS-1:0]  gap_cnt,
                                          input logic [GAP_BITS-1:0]  gap_len);
      dash_type d;
      d.on_cnt  = on_cnt;
      d.gap_cnt = gap_cnt;
      d.in_dash = 1'b0;
      if (gap_cnt != '0) begin
         d.gap_cnt = gap_cnt - GAP_BITS'(1);
      end else begin
         d.in_dash = 1'b1;
         if (on_cnt + DASH_BITS'(1) >= DASH_BITS'(DASH_ON)) begin
            d.on_cnt  = '0;
            d.gap_cnt = (gap_len != '0) ? gap_len - GAP_BITS'(1) : '0;
         end else begin
            d.on_cnt = on_cnt + DASH_BITS'(1);
         end
      end
      return d;
   endfunction

   // Signed step of one coordinate for a direction code
   function automatic logic [COORD_BITS-1:0] dir_ext(input logic [1:0] dir);
      return {{(COORD_BITS-2){dir[1]}}, dir};
   endfunction

   // Direction code from two endpoint coordinates
   function automatic logic [1:0] dir_of(input logic [COORD_BITS-1:0] p0,
                                         input logic [COORD_BITS-1:0] p1);
      logic [1:0] d;
      if (p1 > p0) begin
         d = DIR_POS;
      end else if (p1 < p0) begin
         d = DIR_NEG;
      end else begin
         d = DIR_NONE;
      end
      return d;
   endfunction

endpackage

// ===== hw/rtl/line_pixel_stepper.sv =====
// Top level of the line pixel stepper: integer line stepping with an optional dash pattern.
//
//   channel   direction  handshake                  payload
//   req_      in         req_valid / req_ready      mode, x_start, y_start, x_end, y_end
//   rsp_      out        rsp_valid / rsp_ready      pixel_x, pixel_y, draw_pixel, last_pixel
//   csr_      in         csr_valid / csr_ready      csr_index, csr_data
//
// One transaction per cycle while req_ready is high: every request yields one pixel, which the
// stepping logic writes into the result register, or into the skid register while that one is held.
// A two-entry output (result register plus skid register) keeps req_ready registered;
// req_ready drops only while the skid entry is full.
// Synchronous active-high reset clears the registers, line state and output valid flags.
// csr_ready is always high; writes are meant for idle periods.
`include "assert_macros.svh"

module line_pixel_stepper
   import lps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_mode,
   input  logic [COORD_BITS-1:0]     req_x_start,
   input  logic [COORD_BITS-1:0]     req_y_start,
   input  logic [COORD_BITS-1:0]     req_x_end,
   input  logic [COORD_BITS-1:0]     req_y_end,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COORD_BITS-1:0]     rsp_pixel_x,
   output logic [COORD_BITS-1:0]     rsp_pixel_y,
   output logic                      rsp_draw_pixel,
   output logic                      rsp_last_pixel,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [GAP_BITS-1:0]       csr_data
);

   // Configuration registers
   logic                line_style_ff;
   logic [GAP_BITS-1:0] gap_length_ff;

   // Line state
   logic [COORD_BITS-1:0]    cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]    cur_y_ff, cur_y_in;
   logic signed [ERR_BITS-1:0] error_term_ff, error_term_in;
   logic [COORD_BITS-1:0]    major_delta_ff, major_delta_in;
   logic [COORD_BITS-1:0]    minor_delta_ff, minor_delta_in;
   logic [1:0]               x_dir_ff, x_dir_in;
   logic [1:0]               y_dir_ff, y_dir_in;
   logic                     axes_swapped_ff, axes_swapped_in;
   logic [COORD_BITS-1:0]    steps_left_ff, steps_left_in;
   logic [DASH_BITS-1:0]     dash_on_count_ff, dash_on_count_in;
   logic [GAP_BITS-1:0]      dash_gap_count_ff, dash_gap_count_in;

   // Output entries
   logic      out_valid_ff, out_valid_in;
   logic      skid_valid_ff, skid_valid_in;
   pixel_type out_ff, out_in;
   pixel_type skid_ff, skid_in;

   logic      req_take;
   logic      rsp_take;
   pixel_type result;
   dash_type  dash;

   logic [COORD_BITS-1:0] dx, dy;
   logic [ERR_BITS-1:0]   minor_ext, major_ext;
   logic                  swap;

   assign req_ready = !skid_valid_ff;
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;
   assign csr_ready = 1'b1;

   // Deltas of a new line
   assign dx   = (req_x_end >= req_x_start) ? req_x_end - req_x_start
                                            : req_x_start - req_x_end;
   assign dy   = (req_y_end >= req_y_start) ? req_y_end - req_y_start
                                            : req_y_start - req_y_end;
   assign swap = dy > dx;

   // Compute the next line state and the pixel of this transaction
   always_comb begin
      cur_x_in          = cur_x_ff;
      cur_y_in          = cur_y_ff;
      error_term_in     = error_term_ff;
      major_delta_in    = major_delta_ff;
      minor_delta_in    = minor_delta_ff;
      x_dir_in          = x_dir_ff;
      y_dir_in          = y_dir_ff;
      axes_swapped_in   = axes_swapped_ff;
      steps_left_in     = steps_left_ff;
      dash_on_count_in  = dash_on_count_ff;
      dash_gap_count_in = dash_gap_count_ff;
      minor_ext         = '0;
      major_ext         = '0;
      dash              = dash_step(dash_on_count_ff, dash_gap_count_ff, gap_length_ff);

      if (req_mode == MODE_START) begin
         // Load endpoints; the first pixel is the start point
         x_dir_in          = dir_of(req_x_start, req_x_end);
         y_dir_in          = dir_of(req_y_start, req_y_end);
         axes_swapped_in   = swap;
         major_delta_in    = swap ? dy : dx;
         minor_delta_in    = swap ? dx : dy;
         minor_ext         = ERR_BITS'(minor_delta_in);
         major_ext         = ERR_BITS'(major_delta_in);
         error_term_in     = signed'(minor_ext + (minor_ext << 1) - (major_ext << 1));
         cur_x_in          = req_x_start;
         cur_y_in          = req_y_start;
         steps_left_in     = major_delta_in;
         dash              = dash_step('0, '0, gap_length_ff);
         dash_on_count_in  = dash.on_cnt;
         dash_gap_count_in = dash.gap_cnt;
      end else if (steps_left_ff != '0) begin
         // Advance one pixel along the major axis
         minor_ext = ERR_BITS'(minor_delta_ff);
         major_ext = ERR_BITS'(major_delta_ff);
         if (error_term_ff[ERR_BITS-1]) begin
            if (axes_swapped_ff) begin
               cur_y_in = cur_y_ff + dir_ext(y_dir_ff);
            end else begin
               cur_x_in = cur_x_ff + dir_ext(x_dir_ff);
            end
            error_term_in = signed'(ERR_BITS'(error_term_ff) + (minor_ext << 1));
         end else begin
            cur_x_in      = cur_x_ff + dir_ext(x_dir_ff);
            cur_y_in      = cur_y_ff + dir_ext(y_dir_ff);
            error_term_in = signed'(ERR_BITS'(error_term_ff) + (minor_ext << 1)
                                    - (major_ext << 1));
         end
         steps_left_in     = steps_left_ff - COORD_BITS'(1);
         dash_on_count_in  = dash.on_cnt;
         dash_gap_count_in = dash.gap_cnt;
      end

      result.pixel_x = cur_x_in;
      result.pixel_y = cur_y_in;
      if (req_mode == MODE_STEP && steps_left_ff == '0) begin
         // No active line: hold position, undrawn, flagged last
         result.draw_pixel = 1'b0;
         result.last_pixel = 1'b1;
      end else begin
         result.draw_pixel = (line_style_ff == STYLE_DASHED) ? dash.in_dash : 1'b1;
         result.last_pixel = (steps_left_in == '0);
      end
   end

   // Route results through the result and skid entries
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (rsp_take) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (req_take) begin
         if (!out_valid_ff || rsp_take) begin
            out_valid_in = 1'b1;
            out_in       = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = result;
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_style_ff <= STYLE_SOLID;
         gap_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LINE_STYLE: line_style_ff <= csr_data[0];
            CSR_GAP_LENGTH: gap_length_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Line state, advanced on each request transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff          <= '0;
         cur_y_ff          <= '0;
         error_term_ff     <= '0;
         major_delta_ff    <= '0;
         minor_delta_ff    <= '0;
         x_dir_ff          <= DIR_NONE;
         y_dir_ff          <= DIR_NONE;
         axes_swapped_ff   <= 1'b0;
         steps_left_ff     <= '0;
         dash_on_count_ff  <= '0;
         dash_gap_count_ff <= '0;
      end else if (req_take) begin
         cur_x_ff          <= cur_x_in;
         cur_y_ff          <= cur_y_in;
         error_term_ff     <= error_term_in;
         major_delta_ff    <= major_delta_in;
         minor_delta_ff    <= minor_delta_in;
         x_dir_ff          <= x_dir_in;
         y_dir_ff          <= y_dir_in;
         axes_swapped_ff   <= axes_swapped_in;
         steps_left_ff     <= steps_left_in;
         dash_on_count_ff  <= dash_on_count_in;
         dash_gap_count_ff <= dash_gap_count_in;
      end
   end

   // Output entry valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Output entry payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_x    = out_ff.pixel_x;
   assign rsp_pixel_y    = out_ff.pixel_y;
   assign rsp_draw_pixel = out_ff.draw_pixel;
   assign rsp_last_pixel = out_ff.last_pixel;

   // Checks on the output entries and the line state
   `ASSERT_ALWAYS(a_skid_behind_out, clock, reset, !skid_valid_ff || out_valid_ff, "skid entry full while result entry empty")
   `ASSERT_ALWAYS(a_steps_bounded, clock, reset, steps_left_ff <= major_delta_ff, "steps left exceed major delta")
   `ASSERT_ALWAYS(a_dash_bounded, clock, reset, dash_on_count_ff < DASH_BITS'(DASH_ON), "dash count out of range")
   `ASSERT_NEXT(a_idle_step_holds, clock, reset, req_take && req_mode == MODE_STEP && steps_left_ff == '0, $stable(cur_x_ff) && $stable(cur_y_ff) && $stable(dash_on_count_ff), "idle step changed line state")
   `ASSERT_NEXT(a_take_gives_result, clock, reset, req_take, rsp_valid, "accepted request left no result")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the line pixel stepper: directed table, then random lines.
`timescale 1ns / 1ps

module tb
   import lps_pkg::*;
();

   localparam int COORD_TOP       = (1 << COORD_BITS) - 1;
   localparam int PIXELS_PER_DASH = 5;

   typedef struct packed {
      logic                  mode;
      logic [COORD_BITS-1:0] x0;
      logic [COORD_BITS-1:0] y0;
      logic [COORD_BITS-1:0] x1;
      logic [COORD_BITS-1:0] y1;
   } line_cmd_type;

   typedef struct {
      line_cmd_type cmd;
      bit           typed_in;
      pixel_type    want;
   } table_row_type;

   typedef enum int {RX_OPEN, RX_CHOPPY, RX_SPARSE, RX_BLOCKED} rx_mood_type;

   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_ready;
   logic                      req_mode       = MODE_START;
   logic [COORD_BITS-1:0]     req_x_start    = '0;
   logic [COORD_BITS-1:0]     req_y_start    = '0;
   logic [COORD_BITS-1:0]     req_x_end      = '0;
   logic [COORD_BITS-1:0]     req_y_end      = '0;
   logic                      rsp_valid;
   logic                      rsp_ready      = 1'b0;
   logic [COORD_BITS-1:0]     rsp_pixel_x;
   logic [COORD_BITS-1:0]     rsp_pixel_y;
   logic                      rsp_draw_pixel;
   logic                      rsp_last_pixel;
   logic                      csr_valid      = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index      = CSR_LINE_STYLE;
   logic [GAP_BITS-1:0]       csr_data       = '0;

   // Shadow of the line state and registers
   logic [COORD_BITS-1:0]        pos_x, pos_y;
   logic signed [ERR_BITS-1:0]   line_err;
   logic [COORD_BITS-1:0]        major_len, minor_len, pixels_left;
   logic [1:0]                   dir_x, dir_y;
   logic                         steep;
   logic [DASH_BITS-1:0]         dash_lit;
   logic [GAP_BITS-1:0]          dash_dark;
   logic                         style_reg;
   logic [GAP_BITS-1:0]          gap_reg;

   pixel_type     expected_pixels[$];
   table_row_type directed[$];
   int            fault_count = 0;
   int            burst_left  = 0;
   int            stall_left  = 0;
   rx_mood_type   mood        = RX_OPEN;

   line_pixel_stepper i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_draw_pixel (rsp_draw_pixel),
      .rsp_last_pixel (rsp_last_pixel),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Move one coordinate a single unit in the given direction
   function automatic logic [COORD_BITS-1:0] nudge(input logic [COORD_BITS-1:0] c,
                                                   input logic [1:0]            d);
      logic [COORD_BITS-1:0] n;
      case (d)
         DIR_POS: n = c + COORD_BITS'(1);
         DIR_NEG: n = c - COORD_BITS'(1);
         default: n = c;
      endcase
      return n;
   endfunction

   // Advance the dash pattern once; high while the pixel falls in a dash
   function automatic logic dash_tick();
      logic lit;
      lit = 1'b0;
      if (dash_dark != '0) begin
         dash_dark = dash_dark - GAP_BITS'(1);
      end else begin
         lit = 1'b1;
         dash_lit = dash_lit + DASH_BITS'(1);
         if (int'(dash_lit) >= PIXELS_PER_DASH) begin
            dash_lit = '0;
            dash_dark = (gap_reg != '0) ? gap_reg - GAP_BITS'(1) : '0;
         end
      end
      return lit;
   endfunction

   // Work out the pixel a transaction yields and update the shadow state
   task automatic trace_pixel(input line_cmd_type c, output pixel_type px);
      logic [COORD_BITS-1:0] dx, dy;
      logic                  drawn;
      if (c.mode == MODE_STEP && pixels_left == '0) begin
         // hold the position: no line is active
         px = '{pos_x, pos_y, 1'b0, 1'b1};
      end else begin
         if (c.mode == MODE_START) begin
            dx = (c.x1 >= c.x0) ? c.x1 - c.x0 : c.x0 - c.x1;
            dy = (c.y1 >= c.y0) ? c.y1 - c.y0 : c.y0 - c.y1;
            dir_x = (c.x1 > c.x0) ? DIR_POS : ((c.x1 < c.x0) ? DIR_NEG : DIR_NONE);
            dir_y = (c.y1 > c.y0) ? DIR_POS : ((c.y1 < c.y0) ? DIR_NEG : DIR_NONE);
            steep = dy > dx;
            major_len = steep ? dy : dx;
            minor_len = steep ? dx : dy;
            line_err = ERR_BITS'(3 * int'(minor_len) - 2 * int'(major_len));
            pos_x = c.x0;
            pos_y = c.y0;
            pixels_left = major_len;
            dash_lit = '0;
            dash_dark = '0;
         end else begin
            if (line_err[ERR_BITS-1]) begin
               // major axis only
               if (steep) begin
                  pos_y = nudge(pos_y, dir_y);
               end else begin
                  pos_x = nudge(pos_x, dir_x);
               end
               line_err = line_err + ERR_BITS'(2 * int'(minor_len));
            end else begin
               // diagonal move
               pos_x = nudge(pos_x, dir_x);
               pos_y = nudge(pos_y, dir_y);
               line_err = line_err + ERR_BITS'(2 * int'(minor_len) - 2 * int'(major_len));
            end
            pixels_left = pixels_left - COORD_BITS'(1);
         end
         drawn = dash_tick();
         px = '{pos_x, pos_y, (style_reg == STYLE_DASHED) ? drawn : 1'b1,
                pixels_left == '0};
      end
   endtask

   function automatic table_row_type row(input logic m, input int xa, input int ya,
                                         input int xb, input int yb, input bit typed_in,
                                         input int wx, input int wy, input logic wdraw,
                                         input logic wlast);
      table_row_type r;
      r.cmd.mode   = m;
      r.cmd.x0     = COORD_BITS'(xa);
      r.cmd.y0     = COORD_BITS'(ya);
      r.cmd.x1     = COORD_BITS'(xb);
      r.cmd.y1     = COORD_BITS'(yb);
      r.typed_in   = typed_in;
      r.want       = '{COORD_BITS'(wx), COORD_BITS'(wy), wdraw, wlast};
      return r;
   endfunction

   function automatic line_cmd_type random_cmd(input logic m);
      line_cmd_type c;
      c.mode = m;
      c.x0   = COORD_BITS'($urandom_range(0, COORD_TOP));
      c.y0   = COORD_BITS'($urandom_range(0, COORD_TOP));
      c.x1   = COORD_BITS'($urandom_range(0, COORD_TOP));
      c.y1   = COORD_BITS'($urandom_range(0, COORD_TOP));
      return c;
   endfunction

   // Send one request transaction in bursts with random gaps, then log its pixel
   task automatic issue_cmd(input line_cmd_type c, input bit typed_in, input pixel_type want);
      pixel_type px;
      int        gap;
      gap = 0;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= c.mode;
      req_x_start <= c.x0;
      req_y_start <= c.y0;
      req_x_end   <= c.x1;
      req_y_end   <= c.y1;
      do @(posedge clock); while (!req_ready);
      trace_pixel(c, px);
      expected_pixels.push_back(typed_in ? want : px);
   endtask

   // Hold off requests until every pixel has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write both registers back to back
   task automatic load_regs(input logic style, input logic [GAP_BITS-1:0] gap);
      csr_valid <= 1'b1;
      csr_index <= CSR_LINE_STYLE;
      csr_data  <= GAP_BITS'(style);
      do @(posedge clock); while (!csr_ready);
      style_reg = style;
      csr_index <= CSR_GAP_LENGTH;
      csr_data  <= gap;
      do @(posedge clock); while (!csr_ready);
      gap_reg = gap;
      csr_valid <= 1'b0;
   endtask

   // Place a span of length d on one axis, inside the coordinate range
   task automatic place_span(input int d, output logic [COORD_BITS-1:0] p0,
                             output logic [COORD_BITS-1:0] p1);
      if ($urandom_range(0, 1) == 1) begin
         p0 = COORD_BITS'($urandom_range(0, COORD_TOP - d));
         p1 = p0 + COORD_BITS'(d);
      end else begin
         p0 = COORD_BITS'($urandom_range(d, COORD_TOP));
         p1 = p0 - COORD_BITS'(d);
      end
   endtask

   // Draw random lines, mostly stepped to their end, with some noise mixed in
   task automatic run_lines(input int budget, input int lo_len, input int hi_len);
      int                    issued, span, side_span, steps;
      bit                    wide;
      line_cmd_type          c;
      logic [COORD_BITS-1:0] a0, a1, b0, b1;
      issued = 0;
      while (issued < budget) begin
         if ($urandom_range(0, 9) == 0) begin
            issue_cmd(random_cmd(logic'($urandom_range(0, 1))), 1'b0, '0);
            issued++;
         end else begin
            wide      = ($urandom_range(0, 19) == 0);
            span      = wide ? $urandom_range(0, COORD_TOP) : $urandom_range(lo_len, hi_len);
            side_span = $urandom_range(0, span);
            if ($urandom_range(0, 1) == 1) begin
               place_span(span, a0, a1);
               place_span(side_span, b0, b1);
            end else begin
               place_span(side_span, a0, a1);
               place_span(span, b0, b1);
            end
            c.mode = MODE_START;
            c.x0   = a0;
            c.y0   = b0;
            c.x1   = a1;
            c.y1   = b1;
            issue_cmd(c, 1'b0, '0);
            issued++;
            // mostly the whole line; sometimes cut short or run past its end
            if (wide) begin
               steps = $urandom_range(0, 8);
            end else begin
               case ($urandom_range(0, 5))
                  0: steps = $urandom_range(0, span);
                  1: steps = span + $urandom_range(1, 3);
                  default: steps = span;
               endcase
            end
            repeat (steps) begin
               issue_cmd(random_cmd(MODE_STEP), 1'b0, '0);
               issued++;
            end
            if ($urandom_range(0, 11) == 0) begin
               settle();
            end
         end
      end
   endtask

   // Receiver back-pressure: open, choppy, sparse and blocked stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         mood       <= rx_mood_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(4, 40);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (mood)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_CHOPPY: rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:   rsp_ready <= 1'b0;
      endcase
   end

   // Compare each result transaction with the oldest expected pixel
   always @(posedge clock) begin : pixel_check
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            if (fault_count < 10) begin
               $display("tb: unexpected pixel x=%0d y=%0d draw=%0b last=%0b", rsp_pixel_x,
                        rsp_pixel_y, rsp_draw_pixel, rsp_last_pixel);
            end
            fault_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_x !== want.pixel_x || rsp_pixel_y !== want.pixel_y ||
                rsp_draw_pixel !== want.draw_pixel || rsp_last_pixel !== want.last_pixel) begin
               if (fault_count < 10) begin
                  $display("tb: pixel mismatch expected x=%0d y=%0d draw=%0b last=%0b",
                           want.pixel_x, want.pixel_y, want.draw_pixel, want.last_pixel);
                  $display("tb:                  actual x=%0d y=%0d draw=%0b last=%0b",
                           rsp_pixel_x, rsp_pixel_y, rsp_draw_pixel, rsp_last_pixel);
               end
               fault_count++;
            end
         end
      end
   end

   initial begin : stimulus
      // reset state of the shadow
      pos_x = '0;  pos_y = '0;  line_err = '0;  major_len = '0;  minor_len = '0;
      dir_x = DIR_NONE;  dir_y = DIR_NONE;  steep = 1'b0;  pixels_left = '0;
      dash_lit = '0;  dash_dark = '0;  style_reg = STYLE_SOLID;  gap_reg = '0;

      // step with no line, degenerate lines, extremes, lines in several directions
      directed.push_back(row(MODE_STEP,  4095, 4095, 4095, 4095, 1,    0,    0, 0, 1));
      directed.push_back(row(MODE_START,    0,    0,    0,    0, 1,    0,    0, 1, 1));
      directed.push_back(row(MODE_STEP,  4095,    0, 4095,    0, 1,    0,    0, 0, 1));
      directed.push_back(row(MODE_START, 4095, 4095, 4095, 4095, 1, 4095, 4095, 1, 1));
      directed.push_back(row(MODE_START,    0,    0, 4095, 4095, 1,    0,    0, 1, 0));
      directed.push_back(row(MODE_STEP,     0, 4095,    0, 4095, 0,    0,    0, 0, 0));
      directed.push_back(row(MODE_STEP,  4095,    0, 4095,    0, 0,    0,    0, 0, 0));
      directed.push_back(row(MODE_START, 4095,    0,    0, 4095, 1, 4095,    0, 1, 0));
      directed.push_back(row(MODE_STEP,     0,    0,    0,    0, 0,    0,    0, 0, 0));
      directed.push_back(row(MODE_START,    0, 4095,    3, 4095, 1,    0, 4095, 1, 0));
      directed.push_back(row(MODE_STEP,  2730, 1365, 2730, 1365, 0,    0,    0, 0, 0));
      directed.push_back(row(MODE_STEP,  1365, 2730, 1365, 2730, 0,    0,    0, 0, 0));
      directed.push_back(row(MODE_STEP,  4095, 4095, 4095, 4095, 0,    0,    0, 0, 0));
      directed.push_back(row(MODE_STEP,     0,    0,    0,    0, 1,    3, 4095, 0, 1));
      directed.push_back(row(MODE_START,  100,  200,   98,  205, 1,  100,  200, 1, 0));
      directed.push_back(row(MODE_STEP,  4095,    0, 4095,    0, 0,    0,    0, 0, 0));
      directed.push_back(row(MODE_STEP,     0, 4095,    0, 4095, 0,    0,    0, 0, 0));
      directed.push_back(row(MODE_STEP,  4095,    0, 4095,    0, 0,    0,    0, 0, 0));
      directed.push_back(row(MODE_STEP,     0, 4095,    0, 4095, 0,    0,    0, 0, 0));
      directed.push_back(row(MODE_STEP,  4095,    0, 4095,    0, 0,    0,    0, 0, 0));
      directed.push_back(row(MODE_STEP,     0, 4095,    0, 4095, 1,   98,  205, 0, 1));
      directed.push_back(row(MODE_START, 2730, 1365, 2731, 1365, 1, 2730, 1365, 1, 0));
      directed.push_back(row(MODE_STEP,  1365, 2730, 1365, 2730, 0,    0,    0, 0, 0));
      directed.push_back(row(MODE_START, 1365, 2730, 1365, 2729, 1, 1365, 2730, 1, 0));
      directed.push_back(row(MODE_STEP,  2730, 1365, 2730, 1365, 0,    0,    0, 0, 0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         issue_cmd(directed[i].cmd, directed[i].typed_in, directed[i].want);
      end

      // random phases over register settings, extremes included
      settle();
      load_regs(STYLE_SOLID, GAP_BITS'(0));
      run_lines(80, 1, 12);
      settle();
      load_regs(STYLE_DASHED, GAP_BITS'(0));
      run_lines(60, 1, 16);
      settle();
      load_regs(STYLE_DASHED, GAP_BITS'(1));
      run_lines(50, 1, 16);
      settle();
      load_regs(STYLE_DASHED, GAP_BITS'($urandom_range(2, 12)));
      run_lines(80, 4, 30);
      settle();
      load_regs(STYLE_DASHED, GAP_BITS'(255));
      run_lines(270, 262, 300);
      settle();
      load_regs(STYLE_SOLID, GAP_BITS'($urandom_range(0, 255)));
      run_lines(60, 1, 12);

      // drain and let the pipeline go quiet
      settle();
      repeat (8) @(posedge clock);
      if (fault_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lps_pkg.sv
hw/rtl/line_pixel_stepper.sv
tb/sv/tb.sv
